[rtl/bsa_pkg.sv]
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types and constants of the byte stream accumulator CPU: opcodes,
// framing phases, the decoded command passed from front to back, and the
// result record.
// ----------------------------------------------------------------------------
package bsa_pkg;

    localparam int QUEUE_DEPTH      = 2;
    localparam int NUM_VISIBLE_REGS = 4;

    typedef enum logic [3:0] {
        OP_LOAD  = 4'h1,
        OP_ADD   = 4'h2,
        OP_SUB   = 4'h3,
        OP_STORE = 4'h4,
        OP_NOP   = 4'h5,
        OP_AND   = 4'h6,
        OP_OR    = 4'h7,
        OP_XOR   = 4'h8
    } t_opcode;

    typedef enum logic [1:0] {
        PH_OPCODE,
        PH_INDEX,
        PH_IMM
    } t_phase;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_EXEC,
        CMD_BAD_OP
    } t_cmd_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_REG = 2'd1,
        ST_HALTED  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd_kind   kind;
        t_opcode     opcode;
        logic [7:0]  reg_index;
        logic [7:0]  imm;
    } t_cmd;

    typedef struct packed {
        logic                              reg_write;
        logic [1:0]                        dest_register;
        logic [7:0]                        written_value;
        logic                              mem_write;
        logic [7:0]                        mem_address;
        logic [7:0]                        mem_data;
        t_status                           status;
        logic [NUM_VISIBLE_REGS-1:0][7:0]  reg_values;
    } t_result;

endpackage

[rtl/bsa_front.sv]
// ----------------------------------------------------------------------------
// bsa_front
// Frames the code byte stream into instructions and pushes one decoded
// command per instruction into the queue. Owns the halted flag.
// ----------------------------------------------------------------------------
module bsa_front
    import bsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_code_byte,
    input  logic       i_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase     r_phase, n_phase;
    t_opcode    r_opcode, n_opcode;
    logic [7:0] r_index, n_index;
    logic       r_halted, n_halted;
    logic       accept;
    logic       op_known;

    // once halted, swallow every byte without touching the queue
    assign o_ready  = r_halted || !i_full;
    assign accept   = i_valid && o_ready && !r_halted;
    assign op_known = (i_code_byte[7:4] == 4'h0) && (i_code_byte[3:0] != 4'h0)
                      && (i_code_byte[3:0] <= OP_XOR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_OPCODE;
            r_opcode <= OP_LOAD;
            r_index  <= '0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_opcode <= n_opcode;
            r_index  <= n_index;
            r_halted <= n_halted;
        end
    end

    always_comb begin
        n_phase         = r_phase;
        n_opcode        = r_opcode;
        n_index         = r_index;
        n_halted        = r_halted;
        o_push          = 1'b0;
        o_cmd.kind      = CMD_NOP;
        o_cmd.opcode    = r_opcode;
        o_cmd.reg_index = r_index;
        o_cmd.imm       = i_code_byte;
        if (accept) begin
            unique case (r_phase)
                PH_OPCODE: begin
                    if (op_known && (t_opcode'(i_code_byte[3:0]) == OP_NOP)) begin
                        o_push = 1'b1;
                    end else if (op_known) begin
                        n_opcode = t_opcode'(i_code_byte[3:0]);
                        n_phase  = PH_INDEX;
                    end else begin
                        o_push     = 1'b1;
                        o_cmd.kind = CMD_BAD_OP;
                        n_halted   = 1'b1;
                    end
                end
                PH_INDEX: begin
                    n_index = i_code_byte;
                    n_phase = PH_IMM;
                end
                PH_IMM: begin
                    o_push     = 1'b1;
                    o_cmd.kind = CMD_EXEC;
                    n_phase    = PH_OPCODE;
                end
                default: begin
                    n_phase = PH_OPCODE;
                end
            endcase
        end
    end

    a_no_push_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> !o_push)
        else $error("front pushed a command while halted");

endmodule

[rtl/bsa_queue.sv]
// ----------------------------------------------------------------------------
// bsa_queue
// Short command queue between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module bsa_queue
    import bsa_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd               r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push || i_pop)
        else $error("push into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from an empty queue");

endmodule

[rtl/bsa_back.sv]
// ----------------------------------------------------------------------------
// bsa_back
// Executes decoded commands against the register file and holds the result
// in an output register until the downstream transaction completes.
// ----------------------------------------------------------------------------
module bsa_back
    import bsa_pkg::*;
#(
    parameter int NUM_REGISTERS = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_empty,
    input  t_cmd    i_cmd,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    localparam int IDX_W   = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
    localparam int N_SHOWN = (NUM_REGISTERS < NUM_VISIBLE_REGS) ? NUM_REGISTERS
                                                                 : NUM_VISIBLE_REGS;

    logic [7:0] r_rf [NUM_REGISTERS];
    logic [7:0] n_rf [NUM_REGISTERS];
    logic       r_out_valid;
    t_result    r_out, n_out;
    logic       idx_ok;
    logic [7:0] cur;
    logic [7:0] alu;

    // advance whenever a command is waiting and the output slot is free or being drained
    assign o_pop   = !i_empty && (!r_out_valid || i_ready);
    assign o_valid = r_out_valid;
    assign o_result = r_out;

    assign idx_ok = (i_cmd.reg_index < 8'(NUM_REGISTERS));

    always_comb begin
        cur = '0;
        if (idx_ok) begin
            cur = r_rf[i_cmd.reg_index[IDX_W-1:0]];
        end
    end

    always_comb begin
        unique case (i_cmd.opcode)
            OP_LOAD: alu = i_cmd.imm;
            OP_ADD:  alu = cur + i_cmd.imm;
            OP_SUB:  alu = cur - i_cmd.imm;
            OP_AND:  alu = cur & i_cmd.imm;
            OP_OR:   alu = cur | i_cmd.imm;
            default: alu = cur ^ i_cmd.imm;
        endcase
    end

    always_comb begin
        n_rf  = r_rf;
        n_out = '0;
        unique case (i_cmd.kind)
            CMD_EXEC: begin
                if (i_cmd.opcode == OP_STORE) begin
                    n_out.mem_write   = 1'b1;
                    n_out.mem_address = i_cmd.imm;
                    n_out.mem_data    = cur;
                end else if (idx_ok) begin
                    n_rf[i_cmd.reg_index[IDX_W-1:0]] = alu;
                    n_out.reg_write     = 1'b1;
                    n_out.dest_register = i_cmd.reg_index[1:0];
                    n_out.written_value = alu;
                end
                n_out.status = idx_ok ? ST_OK : ST_BAD_REG;
            end
            CMD_BAD_OP: n_out.status = ST_HALTED;
            default:    n_out.status = ST_OK;
        endcase
        // visible slots past the last register stay zero
        for (int r = 0; r < N_SHOWN; r++) begin
            n_out.reg_values[r] = n_rf[r];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_REGISTERS; r++) begin
                r_rf[r] <= '0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_rf        <= n_rf;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.reg_write && r_out.mem_write))
        else $error("register and memory write in one result");

    a_halt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_HALTED) |-> !r_out.reg_write && !r_out.mem_write)
        else $error("halt result carries a write");

endmodule

[rtl/byte_stream_accumulator_cpu.sv]
// ----------------------------------------------------------------------------
// byte_stream_accumulator_cpu
// Byte-stream accumulator CPU: frames code bytes into instructions and
// executes them against a small register file.
// ----------------------------------------------------------------------------
// Takes one code byte per cycle while the command queue is not full, with
// no bubbles between instructions. NOP is one byte; every other opcode takes
// an index byte and an immediate byte, and the instruction executes on its
// last byte. A result transaction is registered first in the command queue
// between the framing front and the executing back, then in the back's
// output register behind its ALU. Bytes that are not the last of an
// instruction produce no result. An unknown opcode yields one result with
// status 2 and halts the block; after that every byte is accepted and dropped
// until reset.
module byte_stream_accumulator_cpu
    import bsa_pkg::*;
#(
    parameter int NUM_REGISTERS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_code_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_reg_write,
    output logic [1:0] o_dest_register,
    output logic [7:0] o_written_value,
    output logic       o_mem_write,
    output logic [7:0] o_mem_address,
    output logic [7:0] o_mem_data,
    output logic [1:0] o_status,
    output logic [7:0] o_reg0_value,
    output logic [7:0] o_reg1_value,
    output logic [7:0] o_reg2_value,
    output logic [7:0] o_reg3_value
);

    logic    push, pop, full, empty;
    t_cmd    push_cmd, pop_cmd;
    t_result result;

    bsa_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_code_byte (i_code_byte),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    bsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (pop_cmd)
    );

    bsa_back #(
        .NUM_REGISTERS (NUM_REGISTERS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_cmd    (pop_cmd),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (result)
    );

    assign o_reg_write     = result.reg_write;
    assign o_dest_register = result.dest_register;
    assign o_written_value = result.written_value;
    assign o_mem_write     = result.mem_write;
    assign o_mem_address   = result.mem_address;
    assign o_mem_data      = result.mem_data;
    assign o_status        = result.status;
    assign o_reg0_value    = result.reg_values[0];
    assign o_reg1_value    = result.reg_values[1];
    assign o_reg2_value    = result.reg_values[2];
    assign o_reg3_value    = result.reg_values[3];

endmodule
